@@ src/lspt_pkg.sv @@
// Shared types and constants for the learning switch port table.
package lspt_pkg;

  localparam int PORTS_DEF = 16;
  localparam int MASK_W    = 16;
  localparam int PORT_W    = 4;
  localparam int HOST_W    = 8;
  localparam int NUM_W     = 5;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [NUM_W-1:0] NUM_PORTS_RESET = NUM_W'(16);

  // Word select of the register file (paddr bit 2)
  localparam logic REG_NUM_PORTS = 1'b0;

  // Lookup request travelling down the cell chain
  typedef struct packed {
    logic              en;
    logic              hit;
    logic [PORT_W-1:0] port;
    logic [HOST_W-1:0] dst;
  } query_t;

  // Learn strobe broadcast to every cell
  typedef struct packed {
    logic              we;
    logic [PORT_W-1:0] port;
    logic [HOST_W-1:0] host;
  } learn_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_PEND
  } state_t;

endpackage

@@ src/learning_switch_port_table.sv @@
// Learning switch port table: learns one host per port and resolves a forwarding mask.
// Each request (arrival port, source host, destination host) first learns the source for
// the arrival port if that port has nothing learned yet, then walks a chain of PORTS cells,
// one cell per clock, lowest port first; the first valid entry equal to the destination
// wins and gives a one-hot mask, otherwise the mask floods every port in use except the
// arrival port. Ports in use are cfg register num_ports (address 0) saturated to PORTS and
// to 16. An arrival port outside that range learns nothing and returns an all-zero result.
// A request is registered through the PORTS cells of the chain, then into the pending result
// hold stage, then into the output register. The next request is taken only after the result
// is loaded and the state machine is back in idle, so no new request enters while one is in
// flight; while the previous result is still held in the output register the new one waits
// in the hold stage and the input stays stalled.
module learning_switch_port_table #(
  parameter int PORTS = lspt_pkg::PORTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lspt_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [lspt_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [lspt_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  // Request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lspt_pkg::PORT_W-1:0]   in_port,
  input  logic [lspt_pkg::HOST_W-1:0]   in_src_host,
  input  logic [lspt_pkg::HOST_W-1:0]   in_dst_host,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lspt_pkg::MASK_W-1:0]   out_mask,
  output logic                          out_hit,
  output logic [lspt_pkg::PORT_W-1:0]   out_port
);
  import lspt_pkg::*;

  localparam int LIM = (PORTS < MASK_W) ? PORTS : MASK_W;

  state_t            state_r, state_nxt;
  logic [NUM_W-1:0]  num_ports_r, num_ports_nxt;
  logic [NUM_W-1:0]  n_act;
  logic              cfg_we;
  logic              accept;
  logic              port_ok;
  logic [MASK_W-1:0] flood;
  logic [MASK_W-1:0] flood_r;
  learn_t            learn;
  query_t            q_head;
  logic              vld_link [PORTS+1];
  query_t            q_link   [PORTS+1];
  query_t            tail;
  logic              tail_vld;
  logic              out_free;
  logic              cap_pend;
  logic              load_out;
  logic [MASK_W-1:0] pend_mask_r, pend_mask_nxt;
  logic              pend_hit_r;
  logic [PORT_W-1:0] pend_port_r;
  logic              out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0] out_mask_r;
  logic              out_hit_r;
  logic [PORT_W-1:0] out_port_r;

  // Register file
  assign cfg_pready    = 1'b1;
  assign cfg_we        = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_NUM_PORTS);
  assign num_ports_nxt = cfg_we ? cfg_pwdata[NUM_W-1:0] : num_ports_r;
  assign cfg_prdata    = (cfg_paddr[2] == REG_NUM_PORTS) ?
                         {{(DATA_W-NUM_W){1'b0}}, num_ports_r} : '0;

  // Saturate the port count to the table and mask size
  assign n_act = (num_ports_r > NUM_W'(LIM)) ? NUM_W'(LIM) : num_ports_r;

  assign accept  = in_valid && !in_stall;
  assign port_ok = ({1'b0, in_port} < n_act);

  // Flood set for a miss, taken at acceptance
  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      flood[i] = port_ok && (NUM_W'(i) < n_act) && (PORT_W'(i) != in_port);
    end
  end

  assign learn.we   = accept && port_ok;
  assign learn.port = in_port;
  assign learn.host = in_src_host;

  assign q_head.en   = port_ok;
  assign q_head.hit  = 1'b0;
  assign q_head.port = '0;
  assign q_head.dst  = in_dst_host;

  assign vld_link[0] = accept;
  assign q_link[0]   = q_head;

  // Cell chain, one port per cell
  for (genvar k = 0; k < PORTS; k++) begin : g_cell
    lspt_cell #(
      .INDEX (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .learn   (learn),
      .n_act   (n_act),
      .in_vld  (vld_link[k]),
      .q_in    (q_link[k]),
      .out_vld (vld_link[k+1]),
      .q_out   (q_link[k+1])
    );
  end

  assign tail_vld = vld_link[PORTS];
  assign tail     = q_link[PORTS];
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept)   state_nxt = ST_WALK;
      ST_WALK: if (tail_vld) state_nxt = ST_PEND;
      ST_PEND: if (out_free) state_nxt = ST_IDLE;
      default:               state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = 1'b1;
    cap_pend = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_WALK: cap_pend = tail_vld;
      ST_PEND: load_out = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  // Hit gives one port, miss gives the flood set
  assign pend_mask_nxt = tail.hit ? (MASK_W'(1) << tail.port) : flood_r;

  assign out_valid_nxt = load_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      num_ports_r <= NUM_PORTS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_ports_r <= num_ports_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: hold flood set, pending result and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      flood_r <= flood;
    end
    if (cap_pend) begin
      pend_mask_r <= pend_mask_nxt;
      pend_hit_r  <= tail.hit;
      pend_port_r <= tail.hit ? tail.port : '0;
    end
    if (load_out) begin
      out_mask_r <= pend_mask_r;
      out_hit_r  <= pend_hit_r;
      out_port_r <= pend_port_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_mask  = out_mask_r;
  assign out_hit   = out_hit_r;
  assign out_port  = out_port_r;

  // A hit names exactly one port and that port
  a_hit_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> (out_mask == (MASK_W'(1) << out_port)))
    else $error("hit result mask does not match port");

  // A miss reports port zero
  a_miss_port : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> (out_port == '0))
    else $error("miss result with nonzero port");

  // A request reaches the chain end only during a walk
  a_tail_walk : assert property (@(posedge clk) disable iff (!rst_n)
    tail_vld |-> (state_r == ST_WALK))
    else $error("chain output outside a walk");

  // An accepted request starts a walk
  a_accept_walk : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_WALK))
    else $error("accepted request did not start a walk");

  // A pending result waits only while the output register is held
  a_pend_wait : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PEND) && !out_free |=> (state_r == ST_PEND) && out_valid)
    else $error("pending result lost");

endmodule

@@ src/lspt_cell.sv @@
// One table cell: holds a learned host for its port and checks a passing lookup.
module lspt_cell #(
  parameter int INDEX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lspt_pkg::learn_t              learn,
  input  logic [lspt_pkg::NUM_W-1:0]    n_act,
  input  logic                          in_vld,
  input  lspt_pkg::query_t              q_in,
  output logic                          out_vld,
  output lspt_pkg::query_t              q_out
);
  import lspt_pkg::*;

  localparam bit                IN_RANGE = (INDEX < MASK_W);
  localparam logic [PORT_W-1:0] MY_PORT  = PORT_W'(INDEX);
  localparam logic [NUM_W-1:0]  MY_NUM   = NUM_W'(INDEX);

  logic              valid_r, valid_nxt;
  logic [HOST_W-1:0] host_r, host_nxt;
  logic              vld_r;
  query_t            q_r;
  logic              learn_hit;
  logic              match;

  // Learn only into an empty entry; first learning sticks
  assign learn_hit = IN_RANGE && learn.we && (learn.port == MY_PORT) && !valid_r;
  assign valid_nxt = valid_r | learn_hit;
  assign host_nxt  = learn_hit ? learn.host : host_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      vld_r   <= in_vld;
    end
  end

  // Payload: advance the request and hold the host
  always_ff @(posedge clk) begin
    host_r <= host_nxt;
    q_r    <= q_in;
  end

  // Claim the request if no lower port has matched yet
  assign match = vld_r && q_r.en && !q_r.hit && IN_RANGE && (MY_NUM < n_act) &&
                 valid_r && (host_r == q_r.dst);

  always_comb begin
    q_out = q_r;
    if (match) begin
      q_out.hit  = 1'b1;
      q_out.port = MY_PORT;
    end
  end

  assign out_vld = vld_r;

endmodule

@@ bench/tb_learning_switch_port_table.sv @@
// Self-checking testbench for the learning switch port table: random headers, config phases, result scoreboard.
module tb_learning_switch_port_table;
  timeunit 1ns;
  timeprecision 1ps;

  import lspt_pkg::*;

  localparam int  TABLE_PORTS = PORTS_DEF;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  DRAIN_CYCLES = 40;
  localparam logic [ADDR_W-1:0] NUM_PORTS_ADDR = {REG_NUM_PORTS, 2'b00};

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [HOST_W-1:0] src;
    logic [HOST_W-1:0] dst;
  } header_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              hit;
    logic [PORT_W-1:0] port;
  } route_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [DATA_W-1:0]   cfg_pwdata;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;
  logic                in_valid;
  logic                in_stall;
  logic [PORT_W-1:0]   in_port;
  logic [HOST_W-1:0]   in_src_host;
  logic [HOST_W-1:0]   in_dst_host;
  logic                out_valid;
  logic                out_stall;
  logic [MASK_W-1:0]   out_mask;
  logic                out_hit;
  logic [PORT_W-1:0]   out_port;

  // Forwarding table copy, updated as requests are accepted
  logic [NUM_W-1:0]    cfg_num_ports;
  logic                learned [TABLE_PORTS];
  logic [HOST_W-1:0]   host_of [TABLE_PORTS];

  // Generator shadow of the table, updated as headers are queued
  logic                gen_known [TABLE_PORTS];
  logic [HOST_W-1:0]   gen_host [TABLE_PORTS];

  header_t header_q [$];
  route_t  expected_routes [$];

  bit  req_taken;
  int  gap_left;
  int  quiet_in;
  int  stall_left;
  int  quiet_out;
  int  cycles;
  int  errors;
  int  headers_sent;
  int  routes_checked;
  int  hit_count;
  int  flood_count;
  int  drop_count;
  int  settings_used;

  learning_switch_port_table uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_port     (in_port),
    .in_src_host (in_src_host),
    .in_dst_host (in_dst_host),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_mask    (out_mask),
    .out_hit     (out_hit),
    .out_port    (out_port)
  );

  // Free-running clock
  always #10 clk = ~clk;

  // Ports in use: register value saturated to the table size and mask width
  function automatic int active_count(input logic [NUM_W-1:0] n);
    int a;
    a = n;
    if (a > TABLE_PORTS) a = TABLE_PORTS;
    if (a > MASK_W) a = MASK_W;
    return a;
  endfunction

  // Learn the source on a fresh arrival port, then resolve the forwarding mask
  function automatic route_t route_packet(input logic [PORT_W-1:0] port,
                                          input logic [HOST_W-1:0] src,
                                          input logic [HOST_W-1:0] dst);
    route_t r;
    int     act;
    bit     found;
    r = '0;
    found = 1'b0;
    act = active_count(cfg_num_ports);
    if (int'(port) < act) begin
      if (!learned[port]) begin
        learned[port] = 1'b1;
        host_of[port] = src;
      end
      for (int i = 0; i < act; i++) begin
        if (!found && learned[i] && host_of[i] == dst) begin
          found = 1'b1;
          r.hit = 1'b1;
          r.port = PORT_W'(i);
        end
      end
      if (found) begin
        r.mask = MASK_W'(1) << r.port;
      end else begin
        for (int i = 0; i < act; i++)
          if (i != int'(port)) r.mask[i] = 1'b1;
      end
    end
    return r;
  endfunction

  // Idle length: mostly none, some short, a few long, with quiet stretches
  function automatic int idle_length(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Queue one header and track what it will learn
  task automatic add_header(input logic [PORT_W-1:0] p, input logic [HOST_W-1:0] s,
                            input logic [HOST_W-1:0] d);
    header_t h;
    h.port = p;
    h.src = s;
    h.dst = d;
    if (int'(p) < active_count(cfg_num_ports) && !gen_known[p]) begin
      gen_known[p] = 1'b1;
      gen_host[p] = s;
    end
    header_q.push_back(h);
  endtask

  // Queue random headers: mostly valid ports, destinations biased toward learned hosts
  task automatic add_random_headers(input int count);
    int               act;
    int               p;
    int               k;
    logic [HOST_W-1:0] s;
    logic [HOST_W-1:0] d;
    logic [HOST_W-1:0] pool [4];
    pool = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    act = active_count(cfg_num_ports);
    repeat (count) begin
      if (act > 0 && $urandom_range(0, 9) != 0) p = $urandom_range(0, act - 1);
      else p = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) s = pool[$urandom_range(0, 3)];
      else s = HOST_W'($urandom);
      k = (act > 0) ? $urandom_range(0, act - 1) : $urandom_range(0, 15);
      if ($urandom_range(0, 1) == 1 && gen_known[k]) d = gen_host[k];
      else if ($urandom_range(0, 5) == 0) d = pool[$urandom_range(0, 3)];
      else d = HOST_W'($urandom);
      add_header(PORT_W'(p), s, d);
    end
  endtask

  // Hold until every queued header is taken and every result is back
  task automatic wait_idle();
    while (header_q.size() != 0 || in_valid || expected_routes.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write num_ports through the config port while the block is idle
  task automatic set_num_ports(input logic [NUM_W-1:0] value);
    wait_idle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= NUM_PORTS_ADDR;
    cfg_pwdata  <= DATA_W'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_num_ports = value;
    settings_used++;
  endtask

  // Record accepted requests and predict their routes
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_routes.push_back(route_packet(in_port, in_src_host, in_dst_host));
      req_taken = 1'b1;
      headers_sent++;
    end
  end

  // Present requests, inserting random gaps between them
  always @(negedge clk) begin : drive_requests
    header_t nxt;
    if (rst_n) begin
      if (req_taken) begin
        req_taken = 1'b0;
        gap_left = idle_length(quiet_in);
        if (gap_left == 0 && header_q.size() > 0) begin
          nxt = header_q.pop_front();
          in_port     <= nxt.port;
          in_src_host <= nxt.src;
          in_dst_host <= nxt.dst;
          in_valid    <= 1'b1;
        end else begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (header_q.size() > 0) begin
          nxt = header_q.pop_front();
          in_port     <= nxt.port;
          in_src_host <= nxt.src;
          in_dst_host <= nxt.dst;
          in_valid    <= 1'b1;
        end
      end
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin : drive_stall
    int n;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      n = idle_length(quiet_out);
      if (n > 0) begin
        stall_left = n - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each delivered result with the oldest prediction
  always @(posedge clk) begin : check_routes
    route_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_routes.size() == 0) begin
        $error("unexpected result: mask %h hit %0d port %0d", out_mask, out_hit, out_port);
        errors++;
      end else begin
        want = expected_routes.pop_front();
        routes_checked++;
        if (want.hit) hit_count++;
        else if (want.mask != '0) flood_count++;
        else drop_count++;
        if (out_mask !== want.mask) begin
          $error("out_mask mismatch: expected %h, got %h", want.mask, out_mask);
          errors++;
        end
        if (out_hit !== want.hit) begin
          $error("out_hit mismatch: expected %0d, got %0d", want.hit, out_hit);
          errors++;
        end
        if (out_port !== want.port) begin
          $error("out_port mismatch: expected %0d, got %0d", want.port, out_port);
          errors++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [NUM_W-1:0] phase_ports [10];
    int               phase_len [10];
    phase_ports = '{5'd4, 5'd16, 5'd2, 5'd9, 5'd1, 5'd31, 5'd0, 5'd13, 5'd17, 5'd16};
    phase_len   = '{250, 250, 180, 220, 120, 220, 20, 220, 200, 200};
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_valid = 1'b0;
    in_port = '0;
    in_src_host = '0;
    in_dst_host = '0;
    out_stall = 1'b0;
    cfg_num_ports = NUM_PORTS_RESET;
    for (int i = 0; i < TABLE_PORTS; i++) begin
      learned[i] = 1'b0;
      host_of[i] = '0;
      gen_known[i] = 1'b0;
      gen_host[i] = '0;
    end

    // Hold reset, then release it
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Reset port count: self hit, sticky learning, lowest port wins, top port
    add_header(4'd3,  8'h00, 8'h00);
    add_header(4'd5,  8'hFF, 8'h12);
    add_header(4'd5,  8'h77, 8'h77);
    add_header(4'd0,  8'hFF, 8'hFF);
    add_header(4'd15, 8'hAA, 8'hFF);
    add_header(4'd15, 8'h55, 8'hAA);
    add_header(4'd9,  8'h81, 8'h00);
    add_header(4'd10, 8'h7E, 8'h7E);

    // Single port: flood has nowhere to go, upper entries are hidden
    set_num_ports(5'd1);
    add_header(4'd0,  8'h11, 8'hAA);
    add_header(4'd1,  8'h22, 8'hFF);
    add_header(4'd0,  8'h33, 8'hFF);
    add_header(4'd15, 8'h00, 8'h00);

    // No ports in use: every header is dropped
    set_num_ports(5'd0);
    add_header(4'd0,  8'h44, 8'hFF);
    add_header(4'd15, 8'hFF, 8'h00);

    // Oversized count saturates to the full table
    set_num_ports(5'd31);
    add_header(4'd15, 8'h01, 8'h01);
    add_header(4'd12, 8'h81, 8'h81);
    add_header(4'd4,  8'h00, 8'h7E);
    add_header(4'd6,  8'h5A, 8'hA5);

    // Random phases over a spread of port counts
    for (int ph = 0; ph < 10; ph++) begin
      set_num_ports(phase_ports[ph]);
      add_random_headers(phase_len[ph]);
    end

    wait_idle();
    $display("%0d headers over %0d port-count settings; %0d results checked",
             headers_sent, settings_used, routes_checked);
    $display("%0d single-port hits, %0d floods, %0d dropped headers",
             hit_count, flood_count, drop_count);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/lspt_pkg.sv
src/lspt_cell.sv
src/learning_switch_port_table.sv
bench/tb_learning_switch_port_table.sv
